// File: rtl/gyi_pkg.sv
// Package for the gyro yaw integrator: payload, command, config and divider types,
// field widths, fixed-point constants and register indexes.
// No dependencies; every rtl file imports it.
package gyi_pkg;

    // Field widths
    localparam int RATE_W     = 20;
    localparam int COUNT_W    = 16;
    localparam int TS_W       = 32;
    localparam int DT_W       = 20;
    localparam int YAW_W      = 17;
    localparam int DIFF_W     = RATE_W + 1;
    localparam int ACC_W      = 41;
    localparam int CAL_SUM_W  = RATE_W + COUNT_W;
    localparam int MAX_DT_W   = 20;
    localparam int DEADBAND_W = 16;

    // Divider widths, one quotient bit per step
    localparam int DIV_NUM_W = ACC_W;
    localparam int DIV_DEN_W = 20;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Default depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 2'd2;

    localparam logic [COUNT_W-1:0]    CAL_SAMPLES_RST = 16'd500;
    localparam logic [MAX_DT_W-1:0]   MAX_DT_RST      = 20'd100000;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST    = 16'd64;

    // Yaw accumulator is in 1/(128*10^6) deg
    localparam logic signed [ACC_W-1:0] HALF_TURN = 41'sd23040000000;
    localparam logic signed [ACC_W-1:0] FULL_TURN = 41'sd46080000000;
    localparam logic signed [YAW_W-1:0] YAW_OUT_MAX = 17'sd65535;
    localparam logic signed [YAW_W-1:0] YAW_OUT_MIN = -17'sd65536;

    // Yaw scaling by 10^6 = 2^6 * 15625: shift, then multiply by ceil(2^45 / 15625)
    localparam int YAW_PRE_SHIFT   = 6;
    localparam int YAW_SH_W        = ACC_W - YAW_PRE_SHIFT;
    localparam int YAW_MUL_W       = 31;
    localparam int YAW_RECIP_W     = 32;
    localparam int YAW_RECIP_SHIFT = 45;
    localparam int YAW_PROD_W      = YAW_MUL_W + YAW_RECIP_W;
    localparam int YAW_Q_W         = YAW_PROD_W - YAW_RECIP_SHIFT;
    localparam logic [YAW_RECIP_W-1:0] YAW_RECIP     = 32'd2251799814;
    localparam logic [YAW_Q_W-1:0]     YAW_Q_POS_MAX = 18'd65535;
    localparam logic [YAW_Q_W-1:0]     YAW_Q_NEG_MAX = 18'd65536;

    typedef struct packed {
        logic                     req_type;
        logic signed [RATE_W-1:0] gyro_rate;
        logic [TS_W-1:0]          timestamp_us;
    } t_in;

    typedef struct packed {
        logic signed [YAW_W-1:0]  yaw_angle;
        logic                     calibrating;
        logic signed [RATE_W-1:0] bias_value;
    } t_out;

    typedef enum logic {
        CMD_SAMPLE  = 1'b0,
        CMD_RESTART = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                kind;
        logic signed [RATE_W-1:0] rate;
        logic [TS_W-1:0]          ts;
    } t_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0]    calibration_samples;
        logic [MAX_DT_W-1:0]   max_dt_us;
        logic [DEADBAND_W-1:0] deadband_threshold;
    } t_cfg;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic                 neg;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CAL,
        BK_PREP,
        BK_MUL,
        BK_ADD,
        BK_FIX_HI,
        BK_FIX_LO,
        BK_ABS,
        BK_RECIP,
        BK_SAT,
        BK_DIV_GO,
        BK_DIV_WAIT,
        BK_DONE
    } t_bk_state;

endpackage

// File: rtl/gyi_div.sv
// Signed-by-unsigned divider, restoring, one quotient bit per cycle.
// Returns quotient magnitude and sign (truncation toward zero). Uses gyi_pkg.
module gyi_div import gyi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;

    logic [DIV_DEN_W:0]   w_rem_sh;
    logic                 w_fit;
    logic [DIV_DEN_W:0]   w_rem_sub;
    logic [DIV_NUM_W-1:0] w_abs;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_rem_sh  = {r_rem, r_num[DIV_NUM_W-1]};
        w_fit     = (w_rem_sh >= {1'b0, r_den});
        w_rem_sub = w_rem_sh - {1'b0, r_den};
        w_abs     = i_req.dividend[DIV_NUM_W-1] ? DIV_NUM_W'(-i_req.dividend)
                                                : DIV_NUM_W'(i_req.dividend);
    end

    // Load on start, then iterate over every dividend bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_req.dividend[DIV_NUM_W-1];
                r_num  <= w_abs;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_fit ? w_rem_sub[DIV_DEN_W-1:0] : w_rem_sh[DIV_DEN_W-1:0];
                r_num <= {r_num[DIV_NUM_W-2:0], w_fit};
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.neg      = r_neg;
    assign o_rsp.quotient = r_num;

endmodule

// File: rtl/gyi_front.sv
// Front part: takes input items, classifies them as sample or restart,
// and hands them to the queue. Uses gyi_pkg.
module gyi_front import gyi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    input  logic i_q_full,
    output logic o_push,
    output t_cmd o_push_data
);

    logic r_valid;
    t_cmd r_cmd;
    logic w_accept;

    // Hold the input when the queue cannot take the registered item
    assign o_in_stall = r_valid && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;
    assign o_push_data = r_cmd;

    // Register and classify each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.kind <= i_in_data.req_type ? CMD_RESTART : CMD_SAMPLE;
            r_cmd.rate <= i_in_data.gyro_rate;
            r_cmd.ts   <= i_in_data.timestamp_us;
        end
    end

endmodule

// File: rtl/gyi_queue.sv
// Short FIFO of classified commands between the front and back parts.
// Depth is a parameter; uses gyi_pkg for the command type.
module gyi_queue import gyi_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr_ptr;
    logic [IDX_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Write the entry at the tail
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/gyi_back.sv
// Back part: calibration, bias removal, deadband, rate*dt integration,
// wrap to +-180 deg, and the output register. Uses gyi_pkg and drives gyi_div.
module gyi_back import gyi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_q_valid,
    input  t_cmd     i_q_data,
    output logic     o_q_pop,
    output t_div_req o_div_req,
    input  t_div_rsp i_div_rsp,
    output logic     o_out_valid,
    output t_out     o_out_data,
    input  logic     i_out_stall
);

    t_bk_state r_state;
    t_bk_state n_state;

    // Integrator state
    logic                        r_calib_phase;
    logic [COUNT_W-1:0]          r_calib_count;
    logic signed [CAL_SUM_W-1:0] r_calib_sum;
    logic signed [RATE_W-1:0]    r_bias;
    logic [TS_W-1:0]             r_prev_ts;
    logic signed [ACC_W-1:0]     r_yaw;
    logic signed [YAW_W-1:0]     r_yaw_out;

    // Working registers of the current item
    logic signed [RATE_W-1:0]    r_rate;
    logic [TS_W-1:0]             r_ts;
    logic [DT_W-1:0]             r_dt;
    logic signed [DIFF_W-1:0]    r_diff;
    logic signed [ACC_W-1:0]     r_prod;
    logic                        r_yaw_neg;
    logic [YAW_SH_W-1:0]         r_yaw_sh;
    logic                        r_yaw_big;
    logic [YAW_PROD_W-1:0]       r_yaw_prod;

    logic                        r_out_valid;
    t_out                        r_out_data;

    logic [COUNT_W-1:0]          w_cal_n;
    logic                        w_cal_end;
    logic signed [CAL_SUM_W-1:0] n_calib_sum;
    logic [TS_W-1:0]             w_dt_raw;
    logic                        w_dt_ok;
    logic signed [DIFF_W-1:0]    w_diff;
    logic [DIFF_W-1:0]           w_mag;
    logic                        w_dead;
    logic signed [2*DIFF_W-1:0]  w_prod;
    logic [DIV_DEN_W-1:0]        w_cal_div;
    logic                        w_out_load;
    logic [ACC_W-1:0]            w_yaw_mag;
    logic [YAW_PROD_W-1:0]       w_recip_prod;
    logic [YAW_Q_W-1:0]          w_q;
    logic signed [YAW_W-1:0]     w_yaw_sat;

    // Calibration step
    always_comb begin
        w_cal_n     = r_calib_count + 1'b1;
        w_cal_end   = (w_cal_n == '0) || (w_cal_n >= i_cfg.calibration_samples);
        n_calib_sum = r_calib_sum + {{(CAL_SUM_W-RATE_W){r_rate[RATE_W-1]}}, r_rate};
        w_cal_div   = (r_calib_count == '0) ? DIV_DEN_W'(1)
                                            : {{(DIV_DEN_W-COUNT_W){1'b0}}, r_calib_count};
    end

    // Time step and bias-corrected rate with deadband
    always_comb begin
        w_dt_raw = r_ts - r_prev_ts;
        w_dt_ok  = (w_dt_raw != '0) &&
                   (w_dt_raw <= {{(TS_W-MAX_DT_W){1'b0}}, i_cfg.max_dt_us});
        w_diff   = {r_rate[RATE_W-1], r_rate} - {r_bias[RATE_W-1], r_bias};
        w_mag    = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);
        w_dead   = (w_mag < {{(DIFF_W-DEADBAND_W){1'b0}}, i_cfg.deadband_threshold});
        w_prod   = r_diff * $signed({1'b0, r_dt});
    end

    // Scale the yaw magnitude: drop 2^6, then multiply by the reciprocal of 15625
    always_comb begin
        w_yaw_mag    = r_yaw[ACC_W-1] ? ACC_W'(-r_yaw) : ACC_W'(r_yaw);
        w_recip_prod = r_yaw_sh[YAW_MUL_W-1:0] * YAW_RECIP;
        w_q          = r_yaw_prod[YAW_PROD_W-1:YAW_RECIP_SHIFT];
    end

    // Saturate the yaw quotient to the output range
    always_comb begin
        if (!r_yaw_neg) begin
            w_yaw_sat = (r_yaw_big || w_q > YAW_Q_POS_MAX) ? YAW_OUT_MAX
                                                           : $signed(w_q[YAW_W-1:0]);
        end else begin
            w_yaw_sat = (r_yaw_big || w_q > YAW_Q_NEG_MAX) ? YAW_OUT_MIN
                                                           : -$signed(w_q[YAW_W-1:0]);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_data.kind == CMD_RESTART) begin
                        n_state = BK_DONE;
                    end else if (r_calib_phase) begin
                        n_state = BK_CAL;
                    end else begin
                        n_state = BK_PREP;
                    end
                end
            end
            BK_CAL:      n_state = w_cal_end ? BK_DIV_GO : BK_DONE;
            BK_PREP:     n_state = BK_MUL;
            BK_MUL:      n_state = BK_ADD;
            BK_ADD:      n_state = BK_FIX_HI;
            BK_FIX_HI:   n_state = BK_FIX_LO;
            BK_FIX_LO:   n_state = BK_ABS;
            BK_ABS:      n_state = BK_RECIP;
            BK_RECIP:    n_state = BK_SAT;
            BK_SAT:      n_state = BK_DONE;
            BK_DIV_GO:   n_state = BK_DIV_WAIT;
            BK_DIV_WAIT: n_state = i_div_rsp.done ? BK_DONE : BK_DIV_WAIT;
            BK_DONE:     n_state = w_out_load ? BK_IDLE : BK_DONE;
            default:     n_state = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_q_pop            = (r_state == BK_IDLE) && i_q_valid;
        o_div_req.start    = (r_state == BK_DIV_GO);
        o_div_req.dividend = {{(DIV_NUM_W-CAL_SUM_W){r_calib_sum[CAL_SUM_W-1]}}, r_calib_sum};
        o_div_req.divisor  = w_cal_div;
        w_out_load         = (r_state == BK_DONE) && (!r_out_valid || !i_out_stall);
    end

    // Control and integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BK_IDLE;
            r_calib_phase <= 1'b1;
            r_calib_count <= '0;
            r_calib_sum   <= '0;
            r_bias        <= '0;
            r_prev_ts     <= '0;
            r_yaw         <= '0;
            r_yaw_out     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                BK_IDLE: begin
                    if (o_q_pop && i_q_data.kind == CMD_RESTART) begin
                        r_calib_phase <= 1'b1;
                        r_calib_count <= '0;
                        r_calib_sum   <= '0;
                    end
                end
                BK_CAL: begin
                    r_calib_sum   <= n_calib_sum;
                    r_calib_count <= w_cal_n;
                    if (w_cal_end) begin
                        r_prev_ts     <= r_ts;
                        r_calib_phase <= 1'b0;
                    end
                end
                BK_PREP: begin
                    r_prev_ts <= r_ts;
                end
                BK_ADD: begin
                    r_yaw <= r_yaw + r_prod;
                end
                BK_FIX_HI: begin
                    if (r_yaw > HALF_TURN) begin
                        r_yaw <= r_yaw - FULL_TURN;
                    end
                end
                BK_FIX_LO: begin
                    if (r_yaw < -HALF_TURN) begin
                        r_yaw <= r_yaw + FULL_TURN;
                    end
                end
                BK_SAT: begin
                    r_yaw_out <= w_yaw_sat;
                end
                BK_DIV_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_bias <= i_div_rsp.neg ? -$signed(i_div_rsp.quotient[RATE_W-1:0])
                                                : $signed(i_div_rsp.quotient[RATE_W-1:0]);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Item working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (o_q_pop) begin
                    r_rate <= i_q_data.rate;
                    r_ts   <= i_q_data.ts;
                end
            end
            BK_PREP: begin
                r_dt   <= w_dt_ok ? w_dt_raw[DT_W-1:0] : '0;
                r_diff <= w_dead ? '0 : w_diff;
            end
            BK_MUL: begin
                r_prod <= w_prod[ACC_W-1:0];
            end
            BK_ABS: begin
                r_yaw_neg <= r_yaw[ACC_W-1];
                r_yaw_sh  <= w_yaw_mag[ACC_W-1:YAW_PRE_SHIFT];
            end
            BK_RECIP: begin
                r_yaw_big  <= |r_yaw_sh[YAW_SH_W-1:YAW_MUL_W];
                r_yaw_prod <= w_recip_prod;
            end
            default: begin
            end
        endcase
    end

    // Output register: load when the previous result is gone or leaving
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data.yaw_angle   <= r_yaw_out;
            r_out_data.calibrating <= r_calib_phase;
            r_out_data.bias_value  <= r_bias;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/gyro_yaw_integrator.sv
// Gyro yaw integrator, top level. Input items pass through the front register and the queue
// to the back part, which returns a result for each restart and each sample.
// One item is worked on at a time in the back part; the 41-step bias divider sets the longest item,
// and a stalled result holds the back part until the output register can take it.
// Synchronous active-low reset: calibration restarts; bias, time and yaw cleared; registers to defaults.
// Uses gyi_pkg, gyi_front, gyi_queue, gyi_div and gyi_back.
module gyro_yaw_integrator import gyi_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in                   i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out                  o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     w_push;
    t_cmd     w_push_data;
    logic     w_q_full;
    logic     w_q_valid;
    t_cmd     w_q_data;
    logic     w_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.calibration_samples <= CAL_SAMPLES_RST;
            r_cfg.max_dt_us           <= MAX_DT_RST;
            r_cfg.deadband_threshold  <= DEADBAND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CAL_SAMPLES: r_cfg.calibration_samples <= i_cfg_data[COUNT_W-1:0];
                CFG_MAX_DT:      r_cfg.max_dt_us           <= i_cfg_data[MAX_DT_W-1:0];
                CFG_DEADBAND:    r_cfg.deadband_threshold  <= i_cfg_data[DEADBAND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    gyi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    gyi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data)
    );

    gyi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    gyi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_q_pop     (w_pop),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // Front never pushes into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_full))
        else $error("front pushed into a full queue");

    // Divider cannot report done right after a start
    a_div_no_early_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |=> !w_div_rsp.done)
        else $error("divider done one cycle after start");

    // Reset empties the output register
    a_reset_out_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule
